FILE: design/rcfc_pkg.sv
// shared types and constants for the receiver credit flow control block
package rcfc_pkg;

  localparam logic [1:0] CMD_ARRIVE  = 2'd0;
  localparam logic [1:0] CMD_SERVICE = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;

  localparam logic [1:0] KIND_DELIVER = 2'd0;
  localparam logic [1:0] KIND_STOP    = 2'd1;
  localparam logic [1:0] KIND_GRANT   = 2'd2;

  localparam logic [8:0]  BUF_SIZE_RESET    = 9'd200;
  localparam logic [8:0]  STOP_LEVEL_RESET  = 9'd180;
  localparam logic [8:0]  GRANT_LEVEL_RESET = 9'd140;
  localparam logic [24:0] TRUST_ONE         = 25'h1000000;
  localparam logic [24:0] TRUST_RESET       = 25'd167772;
  localparam logic [23:0] TRUST_THIRD_RESET = 24'd55924;
  localparam logic [7:0]  IDLE_LIMIT        = 8'd5;
  localparam logic [7:0]  IDLE_MAX          = 8'hFF;

  // floor(size * pct / 100) as size * (pct * ceil(2^23 / 100)) >> 23, exact for 9-bit sizes
  localparam int          LEVEL_SHIFT = 23;
  localparam logic [31:0] STOP_MUL    = 32'd7549830;
  localparam logic [31:0] GRANT_MUL   = 32'd5872090;

  // floor(x / 3) as x * ceil(2^27 / 3) >> 27, exact for 25-bit x
  localparam int          THIRD_SHIFT = 27;
  localparam logic [25:0] THIRD_MUL   = 26'd44739243;

  typedef struct packed {
    logic        received;
    logic [8:0]  occupancy;
    logic [8:0]  buffer_size;
    logic [8:0]  stop_level;
    logic [8:0]  grant_level;
    logic [31:0] credit;
    logic [31:0] snapshot;
    logic [7:0]  idle;
    logic [24:0] trust;
    logic [23:0] trust_third;
  } fb_in_t;

  typedef struct packed {
    logic [31:0] credit;
    logic [31:0] snapshot;
    logic [7:0]  idle;
    logic [24:0] trust;
    logic        emit;
    logic [1:0]  kind;
    logic [8:0]  grant;
  } fb_out_t;

endpackage

FILE: design/rcfc_ram.sv
// generic single-write, single-read ram with registered read data
module rcfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/rcfc_feedback.sv
// feedback rule: idle tracking, trust adaptation, stop and credit grant decision
module rcfc_feedback
  import rcfc_pkg::*;
(
  input  fb_in_t  fb_in,
  output fb_out_t fb_out
);

  logic [7:0]  idle_inc;
  logic        forced;
  logic        stop_go;
  logic        grant_go;
  logic [8:0]  room;
  logic [24:0] trust_eff;
  logic [33:0] grant_prod;
  logic [25:0] trust_dbl;
  logic [25:0] trust_half_up;
  logic [24:0] trust_dbl_cap;
  logic [24:0] trust_half_cap;

  always_comb begin
    idle_inc = fb_in.idle;
    if (fb_in.snapshot == fb_in.credit && fb_in.idle != IDLE_MAX) begin
      idle_inc = fb_in.idle + 8'd1;
    end
    forced    = idle_inc > IDLE_LIMIT;
    stop_go   = fb_in.occupancy >= fb_in.stop_level;
    grant_go  = forced || (fb_in.occupancy <= fb_in.grant_level && fb_in.credit == 32'd0);
    // only used when occupancy is below the stop level, so no wrap
    room      = fb_in.buffer_size - fb_in.occupancy;
    trust_eff = forced ? {1'b0, fb_in.trust_third} : fb_in.trust;
    grant_prod = 34'(room) * 34'(trust_eff);

    trust_dbl      = {fb_in.trust, 1'b0};
    trust_half_up  = 26'(fb_in.trust) + 26'(fb_in.trust >> 1);
    trust_dbl_cap  = (trust_dbl > 26'(TRUST_ONE)) ? TRUST_ONE : trust_dbl[24:0];
    trust_half_cap = (trust_half_up > 26'(TRUST_ONE)) ? TRUST_ONE : trust_half_up[24:0];

    fb_out.credit = fb_in.credit;
    fb_out.idle   = idle_inc;
    fb_out.trust  = forced ? {1'b0, fb_in.trust_third} : fb_in.trust;
    fb_out.emit   = 1'b0;
    fb_out.kind   = KIND_STOP;
    fb_out.grant  = '0;

    if (stop_go) begin
      fb_out.emit = 1'b1;
      fb_out.kind = KIND_STOP;
      fb_out.idle = '0;
      if (!forced) begin
        fb_out.trust = trust_dbl_cap;
      end
    end else if (grant_go) begin
      fb_out.emit   = 1'b1;
      fb_out.kind   = KIND_GRANT;
      fb_out.grant  = grant_prod[32:24];
      fb_out.credit = 32'(grant_prod[32:24]);
      fb_out.idle   = '0;
      if (!forced) begin
        fb_out.trust = trust_half_cap;
      end
    end

    fb_out.snapshot = fb_in.received ? fb_in.snapshot : fb_out.credit;
  end

endmodule

FILE: design/receiver_credit_flow_control_top.sv
// receiver credit flow control top level: packet fifo, credit state and result pipeline
// result path: each result is registered in the first stage, then in the output register,
// which holds it while out_stall is high
// throughput: one transaction per cycle; the input stalls only while a result waits in
// the first stage behind an output register held by out_stall
// reset: synchronous active-low rst_n clears pointers, occupancy, credit, snapshot and
// idle count, sets trust to 0.01 and buffer size to 200; fifo contents are not cleared
module receiver_credit_flow_control_top
  import rcfc_pkg::*;
#(
  parameter int FIFO_DEPTH   = 256,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_payload,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [31:0] out_payload_res,
  output logic [8:0]  out_grant_count,
  output logic        out_dropped,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_buffer_size
);

  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int OCC_MAX    = (FIFO_DEPTH < 511) ? FIFO_DEPTH : 511;
  localparam int OCC_W      = $clog2(OCC_MAX + 1);
  localparam bit DEPTH_CAPS = (FIFO_DEPTH <= 511);
  localparam int KEEP_W     = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;

  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic [31:0]      credit_r, credit_nxt;
  logic [31:0]      snapshot_r, snapshot_nxt;
  logic [7:0]       idle_r, idle_nxt;
  logic [24:0]      trust_r, trust_nxt;
  logic [23:0]      trust_third_r, trust_third_nxt;
  logic [8:0]       buf_size_r;
  logic [8:0]       stop_level_r;
  logic [8:0]       grant_level_r;

  logic             s1_valid_r, s1_valid_nxt;
  logic [1:0]       s1_kind_r, s1_kind_nxt;
  logic [8:0]       s1_grant_r, s1_grant_nxt;
  logic             s1_drop_r, s1_drop_nxt;

  logic             out_valid_r;
  logic [1:0]       out_kind_r;
  logic [31:0]      out_payload_r;
  logic [8:0]       out_grant_r;
  logic             out_drop_r;

  logic             out_load;
  logic             in_acc;
  logic [8:0]       occ_ext;
  logic             fifo_full;
  logic [31:0]      credit_dec;
  logic             wr_en;
  logic             rd_en;
  logic [KEEP_W-1:0] rd_data;
  logic [50:0]      third_prod;
  logic [31:0]      stop_prod;
  logic [31:0]      grant_prod;
  fb_in_t           fb_in;
  fb_out_t          fb_out;

  assign out_load  = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !out_load;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign occ_ext    = 9'(occ_r);
  assign fifo_full  = (occ_ext >= buf_size_r) || (DEPTH_CAPS && occ_r == OCC_W'(OCC_MAX));
  assign credit_dec = credit_r - 32'd1;

  always_comb begin
    fb_in.received    = (in_cmd == CMD_ARRIVE);
    fb_in.occupancy   = (in_cmd == CMD_ARRIVE) ? occ_ext + 9'd1 : occ_ext;
    fb_in.buffer_size = buf_size_r;
    fb_in.stop_level  = stop_level_r;
    fb_in.grant_level = grant_level_r;
    fb_in.credit      = (in_cmd == CMD_ARRIVE) ? credit_dec : credit_r;
    fb_in.snapshot    = snapshot_r;
    fb_in.idle        = idle_r;
    fb_in.trust       = trust_r;
    fb_in.trust_third = trust_third_r;
  end

  rcfc_feedback u_feedback (
    .fb_in  (fb_in),
    .fb_out (fb_out)
  );

  always_comb begin
    rd_ptr_nxt   = rd_ptr_r;
    wr_ptr_nxt   = wr_ptr_r;
    occ_nxt      = occ_r;
    credit_nxt   = credit_r;
    snapshot_nxt = snapshot_r;
    idle_nxt     = idle_r;
    trust_nxt    = trust_r;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    s1_valid_nxt = 1'b0;
    s1_kind_nxt  = KIND_STOP;
    s1_grant_nxt = '0;
    s1_drop_nxt  = 1'b0;

    if (in_acc) begin
      case (in_cmd)
        CMD_ARRIVE: begin
          credit_nxt = credit_dec;
          if (fifo_full) begin
            s1_valid_nxt = 1'b1;
            s1_kind_nxt  = KIND_STOP;
            s1_drop_nxt  = 1'b1;
          end else begin
            wr_en        = 1'b1;
            wr_ptr_nxt   = (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
            occ_nxt      = occ_r + 1'b1;
            credit_nxt   = fb_out.credit;
            snapshot_nxt = fb_out.snapshot;
            idle_nxt     = fb_out.idle;
            trust_nxt    = fb_out.trust;
            s1_valid_nxt = fb_out.emit;
            s1_kind_nxt  = fb_out.kind;
            s1_grant_nxt = fb_out.grant;
          end
        end
        CMD_SERVICE: begin
          if (occ_r != '0) begin
            rd_en        = 1'b1;
            rd_ptr_nxt   = (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
            occ_nxt      = occ_r - 1'b1;
            s1_valid_nxt = 1'b1;
            s1_kind_nxt  = KIND_DELIVER;
          end
        end
        CMD_TICK: begin
          credit_nxt   = fb_out.credit;
          snapshot_nxt = fb_out.snapshot;
          idle_nxt     = fb_out.idle;
          trust_nxt    = fb_out.trust;
          s1_valid_nxt = fb_out.emit;
          s1_kind_nxt  = fb_out.kind;
          s1_grant_nxt = fb_out.grant;
        end
        default: begin
        end
      endcase
    end

    // keep a third of the trust ready for the forced-grant case
    third_prod      = 51'(trust_nxt) * 51'(THIRD_MUL);
    trust_third_nxt = third_prod[THIRD_SHIFT +: 24];
  end

  assign stop_prod  = 32'(cfg_buffer_size) * STOP_MUL;
  assign grant_prod = 32'(cfg_buffer_size) * GRANT_MUL;

  rcfc_ram #(
    .WIDTH (KEEP_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_ptr_r),
    .wr_data (in_payload[KEEP_W-1:0]),
    .rd_en   (rd_en),
    .rd_addr (rd_ptr_r),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r      <= '0;
      wr_ptr_r      <= '0;
      occ_r         <= '0;
      credit_r      <= '0;
      snapshot_r    <= '0;
      idle_r        <= '0;
      trust_r       <= TRUST_RESET;
      trust_third_r <= TRUST_THIRD_RESET;
      buf_size_r    <= BUF_SIZE_RESET;
      stop_level_r  <= STOP_LEVEL_RESET;
      grant_level_r <= GRANT_LEVEL_RESET;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      rd_ptr_r      <= rd_ptr_nxt;
      wr_ptr_r      <= wr_ptr_nxt;
      occ_r         <= occ_nxt;
      credit_r      <= credit_nxt;
      snapshot_r    <= snapshot_nxt;
      idle_r        <= idle_nxt;
      trust_r       <= trust_nxt;
      trust_third_r <= trust_third_nxt;
      if (cfg_valid && cfg_ready) begin
        buf_size_r    <= cfg_buffer_size;
        stop_level_r  <= stop_prod[LEVEL_SHIFT +: 9];
        grant_level_r <= grant_prod[LEVEL_SHIFT +: 9];
      end
      if (!in_stall) begin
        s1_valid_r <= s1_valid_nxt;
      end
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // payload side of the two stages
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_kind_r  <= s1_kind_nxt;
      s1_grant_r <= s1_grant_nxt;
      s1_drop_r  <= s1_drop_nxt;
    end
    if (out_load) begin
      out_kind_r    <= s1_kind_r;
      out_payload_r <= (s1_kind_r == KIND_DELIVER) ? 32'(rd_data) : 32'd0;
      out_grant_r   <= s1_grant_r;
      out_drop_r    <= s1_drop_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_payload_res = out_payload_r;
  assign out_grant_count = out_grant_r;
  assign out_dropped     = out_drop_r;

endmodule

FILE: design/rcfc_checker.sv
// port-level checks for the receiver credit flow control top level, with bind
module rcfc_assertions
  import rcfc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_kind,
  input logic [31:0] out_payload_res,
  input logic [8:0]  out_grant_count,
  input logic        out_dropped
);

  // nothing leaves the block in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // drop flag only on a stop transaction
  a_drop_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_dropped) |-> (out_kind == KIND_STOP))
    else $error("dropped flag on a non-stop result");

  // delivered packets carry no grant and no drop flag
  a_deliver_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_DELIVER) |-> (out_grant_count == 9'd0 && !out_dropped))
    else $error("delivered packet with grant or drop set");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_kind)
      && $stable(out_payload_res) && $stable(out_grant_count) && $stable(out_dropped)))
    else $error("stalled result changed");

endmodule

bind receiver_credit_flow_control_top rcfc_assertions u_rcfc_assertions (.*);

FILE: tb/rcfc_checker.sv
// scoreboard for the receiver credit flow control block: predicts and compares results
`timescale 1ns / 1ps
module rcfc_checker
  import rcfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_payload,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_kind,
  input  logic [31:0] out_payload_res,
  input  logic [8:0]  out_grant_count,
  input  logic        out_dropped,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [8:0]  cfg_buffer_size,
  output int          failures,
  output int          pending
);

  localparam int FIFO_DEPTH = 256;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] word;
    logic [8:0]  grant;
    logic        dropped;
  } result_t;

  logic [31:0] packet_mem [FIFO_DEPTH];
  logic [7:0]  rd_ptr;
  logic [7:0]  wr_ptr;
  logic [8:0]  occ;
  logic [31:0] credit;
  logic [31:0] snapshot;
  logic [7:0]  idle_cnt;
  logic [31:0] trust;
  logic [8:0]  buf_size;

  result_t due_results [$];
  int      fail_cnt = 0;
  int      due_cnt  = 0;

  assign failures = fail_cnt;
  assign pending  = due_cnt;

  function automatic void add_result(input logic [1:0] kind, input logic [31:0] word,
                                     input logic [8:0] grant, input logic dropped);
    result_t r;
    r.kind    = kind;
    r.word    = word;
    r.grant   = grant;
    r.dropped = dropped;
    due_results.push_back(r);
  endfunction

  function automatic void run_feedback(input logic received);
    logic        forced;
    logic [31:0] stop_lvl;
    logic [31:0] grant_lvl;
    logic [31:0] room;
    logic [63:0] scaled;
    forced    = 1'b0;
    stop_lvl  = (32'(buf_size) * 32'd90) / 32'd100;
    grant_lvl = (32'(buf_size) * 32'd70) / 32'd100;
    if (snapshot == credit && idle_cnt != IDLE_MAX) idle_cnt++;
    // too long without credit movement: force a grant and lose confidence
    if (idle_cnt > IDLE_LIMIT) begin
      forced = 1'b1;
      trust  = trust / 32'd3;
    end
    if (32'(occ) >= stop_lvl) begin
      if (!forced) trust = (trust * 2 > 32'(TRUST_ONE)) ? 32'(TRUST_ONE) : trust * 2;
      idle_cnt = '0;
      add_result(KIND_STOP, '0, '0, 1'b0);
    end else if ((32'(occ) <= grant_lvl && credit == '0) || forced) begin
      room   = 32'(buf_size) - 32'(occ);
      scaled = (64'(room) * 64'(trust)) >> 24;
      credit = 32'(scaled);
      add_result(KIND_GRANT, '0, scaled[8:0], 1'b0);
      if (!forced) begin
        scaled = (64'(trust) * 64'd3) >> 1;
        trust  = (scaled > 64'(TRUST_ONE)) ? 32'(TRUST_ONE) : 32'(scaled);
      end
      idle_cnt = '0;
    end
    if (!received) snapshot = credit;
  endfunction

  function automatic void step_receiver(input logic [1:0] cmd, input logic [31:0] word);
    case (cmd)
      CMD_ARRIVE: begin
        credit = credit - 32'd1;
        if (occ >= buf_size || 32'(occ) >= FIFO_DEPTH) begin
          add_result(KIND_STOP, '0, '0, 1'b1);
        end else begin
          packet_mem[wr_ptr] = word;
          wr_ptr++;
          occ++;
          run_feedback(1'b1);
        end
      end
      CMD_SERVICE: begin
        if (occ != '0) begin
          add_result(KIND_DELIVER, packet_mem[rd_ptr], '0, 1'b0);
          rd_ptr++;
          occ--;
        end
      end
      CMD_TICK: run_feedback(1'b0);
      default: ;
    endcase
  endfunction

  function automatic void compare_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      fail_cnt++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      rd_ptr   = '0;
      wr_ptr   = '0;
      occ      = '0;
      credit   = '0;
      snapshot = '0;
      idle_cnt = '0;
      trust    = 32'(TRUST_RESET);
      buf_size = BUF_SIZE_RESET;
      due_results.delete();
    end else begin
      // a result never leaves in the cycle that takes its transaction, so check before predicting
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected result, expected none, got kind %0d word %0h grant %0d drop %0b",
                   $time, out_kind, out_payload_res, out_grant_count, out_dropped);
        end else begin
          want = due_results.pop_front();
          compare_field("kind", 32'(want.kind), 32'(out_kind));
          compare_field("payload_res", want.word, out_payload_res);
          compare_field("grant_count", 32'(want.grant), 32'(out_grant_count));
          compare_field("dropped", 32'(want.dropped), 32'(out_dropped));
        end
      end
      if (cfg_valid && cfg_ready) buf_size = cfg_buffer_size;
      if (in_valid && !in_stall) step_receiver(in_cmd, in_payload);
    end
    due_cnt = due_results.size();
  end

endmodule

FILE: tb/testbench.sv
// top of the receiver credit flow control testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module testbench;
  import rcfc_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         HOLD_CYCLES = 300;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic [1:0]  in_cmd          = CMD_ARRIVE;
  logic [31:0] in_payload      = '0;
  logic        out_stall       = 1'b0;
  logic        cfg_valid       = 1'b0;
  logic [8:0]  cfg_buffer_size = BUF_SIZE_RESET;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [31:0] out_payload_res;
  logic [8:0]  out_grant_count;
  logic        out_dropped;
  logic        cfg_ready;

  int failures;
  int pending;
  int tx_idle_pct = 8;
  int rx_idle_pct = 71;
  int hold_reqs   = 0;
  int cycles      = 0;

  always #5 clk = ~clk;

  receiver_credit_flow_control_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_payload      (in_payload),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_payload_res (out_payload_res),
    .out_grant_count (out_grant_count),
    .out_dropped     (out_dropped),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_buffer_size (cfg_buffer_size)
  );

  rcfc_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_payload      (in_payload),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_payload_res (out_payload_res),
    .out_grant_count (out_grant_count),
    .out_dropped     (out_dropped),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_buffer_size (cfg_buffer_size),
    .failures        (failures),
    .pending         (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: random stalls, or a long hold-off when one is requested
  initial begin : receiver
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send(input logic [1:0] cmd, input logic [31:0] word);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= cmd;
    in_payload <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    // items without a result may still be in flight
    repeat (6) @(negedge clk);
  endtask

  task automatic write_buffer_size(input logic [8:0] size);
    settle();
    cfg_valid       <= 1'b1;
    cfg_buffer_size <= size;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // bursts of filling, draining and quiet traffic with a little unused-command noise
  task automatic random_phase(input int items);
    int n;
    int style;
    int burst;
    int pick;
    n = 0;
    while (n < items) begin
      style = $urandom_range(2);
      burst = $urandom_range(4, 24);
      repeat (burst) begin
        pick = $urandom_range(99);
        if (pick < 3) begin
          send(CMD_UNUSED, $urandom);
        end else begin
          n++;
          case (style)
            0:       pick = (pick < 73) ? 0 : (pick < 83) ? 1 : 2;
            1:       pick = (pick < 18) ? 0 : (pick < 78) ? 1 : 2;
            default: pick = (pick < 15) ? 0 : (pick < 30) ? 1 : 2;
          endcase
          case (pick)
            0:       send(CMD_ARRIVE, $urandom);
            1:       send(CMD_SERVICE, $urandom);
            default: send(CMD_TICK, $urandom);
          endcase
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [8:0] sizes [10];
    sizes = '{9'd256, 9'd1, 9'd4, 9'd511, 9'd0, 9'd200,
              9'($urandom_range(1, 256)), 9'd100, 9'($urandom_range(1, 256)), 9'd256};
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset buffer size: grant from empty, payload extremes, empty slot, idle forcing
    send(CMD_TICK, '0);
    send(CMD_ARRIVE, 32'h0000_0000);
    send(CMD_ARRIVE, 32'hFFFF_FFFF);
    send(CMD_ARRIVE, 32'hA5A5_A5A5);
    repeat (4) send(CMD_SERVICE, '0);
    send(CMD_UNUSED, 32'hFFFF_FFFF);
    repeat (7) send(CMD_TICK, '0);

    // single-packet buffer: second arrival is dropped
    write_buffer_size(9'd1);
    send(CMD_ARRIVE, 32'h5A5A_5A5A);
    send(CMD_ARRIVE, 32'h1234_5678);
    send(CMD_TICK, '0);
    send(CMD_SERVICE, '0);

    // zero size stops on every rule run, oversized size is still capped by the fifo
    write_buffer_size(9'd0);
    send(CMD_TICK, '0);
    send(CMD_ARRIVE, 32'hFFFF_0000);
    write_buffer_size(9'd511);
    send(CMD_ARRIVE, 32'h0000_FFFF);
    send(CMD_TICK, '0);
    send(CMD_SERVICE, '0);

    // long receiver hold-off while arrivals keep coming so the block backs up;
    // the service slots each give a result, so the result stages fill and stall the input
    write_buffer_size(9'd256);
    hold_reqs++;
    repeat (120) send(CMD_ARRIVE, $urandom);
    repeat (8) send(CMD_SERVICE, '0);

    for (int phase = 0; phase < 10; phase++) begin
      if (phase == 4) begin
        tx_idle_pct = 71;
        rx_idle_pct = 8;
      end else if (phase == 7) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_buffer_size(sizes[phase]);
      random_phase(60);
    end

    settle();
    repeat (10) @(negedge clk);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
design/rcfc_pkg.sv
design/rcfc_ram.sv
design/rcfc_feedback.sv
design/receiver_credit_flow_control_top.sv
design/rcfc_checker.sv
tb/rcfc_checker.sv
tb/testbench.sv
